// File: src/ssg_pkg.sv
// Shared types and fixed field widths for the Shamir share generator.
// No dependencies; imported by every module of the block.
package ssg_pkg;

    localparam int unsigned IN_W      = 7;
    localparam int unsigned DEG_W     = 3;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned VAL_W     = 7;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 4;
    localparam int unsigned NUM_COEF_IN = 4;

    localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_COUNT = 1'd1;

    localparam logic [DEG_W-1:0] DEG_RESET = 3'd1;
    localparam logic [CNT_W-1:0] CNT_RESET = 4'd3;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

// File: src/ssg_front.sv
// Front end: configuration registers, input reduction mod the prime, degree masking.
// Depends on ssg_pkg; feeds ssg_queue.
module ssg_front
    import ssg_pkg::*;
#(
    parameter int unsigned PRIME_MODULUS = 97,
    parameter int unsigned MAX_DEGREE    = 4,
    parameter int unsigned MAX_SHARES    = 8,
    parameter int unsigned PW            = $clog2(PRIME_MODULUS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_valid,
    input  logic                         i_full,
    input  logic [IN_W-1:0]              i_secret_value,
    input  logic [IN_W-1:0]              i_coef_one,
    input  logic [IN_W-1:0]              i_coef_two,
    input  logic [IN_W-1:0]              i_coef_three,
    input  logic [IN_W-1:0]              i_coef_four,
    output logic                         o_push,
    output logic [MAX_DEGREE:0][PW-1:0]  o_coef,
    output logic [CNT_W-1:0]             o_cnt
);

    localparam int unsigned IN_RANGE = 2 ** IN_W;

    logic [DEG_W-1:0] r_poly_degree;
    logic [CNT_W-1:0] r_share_count;
    logic [PW-1:0]    w_mod_lut [IN_RANGE];
    logic [IN_W-1:0]  w_raw [NUM_COEF_IN+1];
    logic [DEG_W-1:0] w_deg;

    for (genvar g = 0; g < IN_RANGE; g++) begin : g_lut
        localparam int unsigned Res = g % PRIME_MODULUS;
        assign w_mod_lut[g] = PW'(Res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_degree <= DEG_RESET;
            r_share_count <= CNT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_POLY_DEGREE: r_poly_degree <= i_cfg_data[DEG_W-1:0];
                REG_SHARE_COUNT: r_share_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_raw[0] = i_secret_value;
    assign w_raw[1] = i_coef_one;
    assign w_raw[2] = i_coef_two;
    assign w_raw[3] = i_coef_three;
    assign w_raw[4] = i_coef_four;

    always_comb begin
        w_deg = (r_poly_degree == '0) ? DEG_W'(1) : r_poly_degree;
        if (w_deg > DEG_W'(MAX_DEGREE)) begin
            w_deg = DEG_W'(MAX_DEGREE);
        end
    end

    always_comb begin
        o_cnt = (r_share_count == '0) ? CNT_W'(1) : r_share_count;
        if (o_cnt > CNT_W'(MAX_SHARES)) begin
            o_cnt = CNT_W'(MAX_SHARES);
        end
        if (32'(o_cnt) > PRIME_MODULUS - 1) begin
            o_cnt = CNT_W'(PRIME_MODULUS - 1);
        end
    end

    always_comb begin
        o_coef[0] = w_mod_lut[w_raw[0]];
        for (int j = 1; j <= MAX_DEGREE; j++) begin
            o_coef[j] = (DEG_W'(j) <= w_deg) ? w_mod_lut[w_raw[j]] : '0;
        end
    end

    assign o_push = i_valid && !i_full;

endmodule

// File: src/ssg_queue.sv
// Two-entry queue between the front end and the share pipeline.
// Depends on ssg_pkg for the status struct.
module ssg_queue
    import ssg_pkg::*;
#(
    parameter int unsigned IW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [IW-1:0] i_item,
    input  logic          i_pop,
    output t_q_status     o_status,
    output logic [IW-1:0] o_item
);

    logic [IW-1:0] r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item             = r_mem[r_rd_ptr];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == 2'd2);

endmodule

// File: src/ssg_back.sv
// Back end: share sequencer and pipelined Horner evaluation mod the prime.
// Depends on ssg_pkg; reads the head of ssg_queue.
module ssg_back
    import ssg_pkg::*;
#(
    parameter int unsigned PRIME_MODULUS = 97,
    parameter int unsigned MAX_DEGREE    = 4,
    parameter int unsigned MAX_SHARES    = 8,
    parameter int unsigned PW            = $clog2(PRIME_MODULUS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_head_valid,
    input  logic [MAX_DEGREE:0][PW-1:0]  i_head_coef,
    input  logic [CNT_W-1:0]             i_head_cnt,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [CNT_W-1:0]             o_share_index,
    output logic [VAL_W-1:0]             o_share_value,
    output logic                         o_last_share
);

    localparam int unsigned VW = $clog2((MAX_SHARES + 1) * PRIME_MODULUS);
    localparam int unsigned NS = 2 * MAX_DEGREE + 1;

    logic                        r_vld  [NS];
    logic [VW-1:0]               r_val  [NS];
    logic [MAX_DEGREE:0][PW-1:0] r_coef [NS];
    logic [CNT_W-1:0]            r_x    [NS];
    logic                        r_last [NS];

    logic                        n_vld  [NS];
    logic [VW-1:0]               n_val  [NS];
    logic [MAX_DEGREE:0][PW-1:0] n_coef [NS];
    logic [CNT_W-1:0]            n_x    [NS];
    logic                        n_last [NS];

    logic [CNT_W-1:0] r_x_idx;
    logic             w_adv;
    logic             w_issue;
    logic             w_last;

    assign w_adv   = !r_vld[NS-1] || !i_stall;
    assign w_issue = i_head_valid && w_adv;
    assign w_last  = (r_x_idx == i_head_cnt);
    assign o_pop   = w_issue && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_idx <= CNT_W'(1);
        end else if (w_issue) begin
            r_x_idx <= w_last ? CNT_W'(1) : r_x_idx + CNT_W'(1);
        end
    end

    always_comb begin
        logic [VW-1:0] v_sub;
        n_vld[0]  = w_issue;
        n_val[0]  = VW'(i_head_coef[MAX_DEGREE]);
        n_coef[0] = i_head_coef;
        n_x[0]    = r_x_idx;
        n_last[0] = w_last;
        for (int k = 0; k < MAX_DEGREE; k++) begin
            n_vld[2*k+1]  = r_vld[2*k];
            n_coef[2*k+1] = r_coef[2*k];
            n_x[2*k+1]    = r_x[2*k];
            n_last[2*k+1] = r_last[2*k];
            n_val[2*k+1]  = VW'(VW'(r_val[2*k][PW-1:0]) * VW'(r_x[2*k])
                            + VW'(r_coef[2*k][MAX_DEGREE-1-k]));

            v_sub = '0;
            for (int m = 1; m <= MAX_SHARES; m++) begin
                if (r_val[2*k+1] >= VW'(m * PRIME_MODULUS)) begin
                    v_sub = VW'(m * PRIME_MODULUS);
                end
            end
            n_vld[2*k+2]  = r_vld[2*k+1];
            n_coef[2*k+2] = r_coef[2*k+1];
            n_x[2*k+2]    = r_x[2*k+1];
            n_last[2*k+2] = r_last[2*k+1];
            n_val[2*k+2]  = r_val[2*k+1] - v_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= n_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < NS; s++) begin
                r_val[s]  <= n_val[s];
                r_coef[s] <= n_coef[s];
                r_x[s]    <= n_x[s];
                r_last[s] <= n_last[s];
            end
        end
    end

    assign o_valid       = r_vld[NS-1];
    assign o_share_index = r_x[NS-1];
    assign o_share_value = VAL_W'(r_val[NS-1]);
    assign o_last_share  = r_last[NS-1];

endmodule

// File: src/shamir_share_generator.sv
// Shamir share generator top: front end, two-entry queue, Horner share pipeline.
// Depends on ssg_pkg, ssg_front, ssg_queue and ssg_back.
// Throughput: one share per cycle while an item is queued and i_stall does not hold a share at the output;
// an item gives share_count shares (at most 8), issued through the single issue port of the share sequencer.
// Reset: synchronous active low; poly_degree returns to 1, share_count to 3, pipeline empties.
module shamir_share_generator
    import ssg_pkg::*;
#(
    parameter int unsigned PRIME_MODULUS = 97,
    parameter int unsigned MAX_DEGREE    = 4,
    parameter int unsigned MAX_SHARES    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [IN_W-1:0]      i_secret_value,
    input  logic [IN_W-1:0]      i_coef_one,
    input  logic [IN_W-1:0]      i_coef_two,
    input  logic [IN_W-1:0]      i_coef_three,
    input  logic [IN_W-1:0]      i_coef_four,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CNT_W-1:0]     o_share_index,
    output logic [VAL_W-1:0]     o_share_value,
    output logic                 o_last_share
);

    localparam int unsigned PW = $clog2(PRIME_MODULUS);
    localparam int unsigned IW = (MAX_DEGREE + 1) * PW + CNT_W;

    logic                        w_push;
    logic                        w_pop;
    logic [MAX_DEGREE:0][PW-1:0] w_front_coef;
    logic [CNT_W-1:0]            w_front_cnt;
    logic [MAX_DEGREE:0][PW-1:0] w_head_coef;
    logic [CNT_W-1:0]            w_head_cnt;
    logic [IW-1:0]               w_q_in;
    logic [IW-1:0]               w_q_out;
    t_q_status                   w_q_status;

    ssg_front #(
        .PRIME_MODULUS (PRIME_MODULUS),
        .MAX_DEGREE    (MAX_DEGREE),
        .MAX_SHARES    (MAX_SHARES),
        .PW            (PW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_full         (w_q_status.full),
        .i_secret_value (i_secret_value),
        .i_coef_one     (i_coef_one),
        .i_coef_two     (i_coef_two),
        .i_coef_three   (i_coef_three),
        .i_coef_four    (i_coef_four),
        .o_push         (w_push),
        .o_coef         (w_front_coef),
        .o_cnt          (w_front_cnt)
    );

    assign w_q_in = {w_front_coef, w_front_cnt};

    ssg_queue #(
        .IW (IW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_q_in),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_item   (w_q_out)
    );

    assign w_head_coef = w_q_out[IW-1:CNT_W];
    assign w_head_cnt  = w_q_out[CNT_W-1:0];

    ssg_back #(
        .PRIME_MODULUS (PRIME_MODULUS),
        .MAX_DEGREE    (MAX_DEGREE),
        .MAX_SHARES    (MAX_SHARES),
        .PW            (PW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_q_status.not_empty),
        .i_head_coef   (w_head_coef),
        .i_head_cnt    (w_head_cnt),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_share_index (o_share_index),
        .o_share_value (o_share_value),
        .o_last_share  (o_last_share)
    );

    assign o_stall = w_q_status.full;

endmodule
